// ----- sv/mrwt_pkg.sv -----
// Shared constants and types for the Miller-Rabin witness test core.
package mrwt_pkg;

  localparam int unsigned ValueBits = 62;
  localparam int unsigned CntBits   = $clog2(ValueBits + 1);

  typedef logic [ValueBits-1:0] value_t;
  typedef logic [CntBits-1:0]   cnt_t;

  typedef enum logic [1:0] {
    CLS_FAIL = 2'd0,
    CLS_PASS = 2'd1,
    CLS_TEST = 2'd2
  } class_e;

  typedef struct packed {
    class_e cls;
    value_t n;
    value_t a;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_SPLIT,
    ST_MSEL,
    ST_MUL,
    ST_MDONE,
    ST_DONE
  } state_e;

endpackage

// ----- sv/mrwt_front.sv -----
// Front end: accepts transactions, classifies them and holds them in a one-entry queue.
module mrwt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mrwt_pkg::value_t candidate_i,
  input  mrwt_pkg::value_t witness_i,
  output logic            busy_o,
  output logic            job_valid_o,
  output mrwt_pkg::job_t  job_o,
  input  logic            job_take_i
);

  logic           full_q, full_d;
  mrwt_pkg::job_t job_q;
  mrwt_pkg::class_e cls;

  always_comb begin
    if (candidate_i < mrwt_pkg::ValueBits'(2)) cls = mrwt_pkg::CLS_FAIL;
    else if (candidate_i == mrwt_pkg::ValueBits'(2)) cls = mrwt_pkg::CLS_PASS;
    else if (!candidate_i[0]) cls = mrwt_pkg::CLS_FAIL;
    else cls = mrwt_pkg::CLS_TEST;
  end

  assign busy_o      = full_q;
  assign job_valid_o = full_q;
  assign job_o       = job_q;

  always_comb begin
    full_d = full_q;
    if (job_take_i) full_d = 1'b0;
    if (start_i && !full_q) full_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !full_q) begin
      job_q <= '{cls: cls, n: candidate_i, a: witness_i};
    end
  end

endmodule

// ----- sv/mrwt_back.sv -----
// Back end: modular exponentiation and squaring on one shared shift-and-add modular unit.
module mrwt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  mrwt_pkg::job_t job_i,
  output logic           job_take_o,
  output logic           done_o,
  output logic           probable_prime_o
);

  localparam int unsigned W = mrwt_pkg::ValueBits;

  mrwt_pkg::state_e st_q, st_d;
  mrwt_pkg::value_t n_q, base_q, acc_q, d_q, cur_q, prev_q;
  mrwt_pkg::value_t mx_q, my_q, mp_q, rem_q;
  mrwt_pkg::cnt_t   s_q, rcnt_q;
  logic             sq_phase_q, mul_base_q, res_q, fail_q;

  logic [W:0] dbl, sum, red_sh;
  mrwt_pkg::value_t dbl_r, sum_r, nm1;

  assign nm1    = n_q - W'(1);
  assign dbl    = {mx_q, 1'b0};
  assign dbl_r  = (dbl >= {1'b0, n_q}) ? W'(dbl - {1'b0, n_q}) : dbl[W-1:0];
  assign sum    = {1'b0, mp_q} + {1'b0, mx_q};
  assign sum_r  = (sum >= {1'b0, n_q}) ? W'(sum - {1'b0, n_q}) : sum[W-1:0];
  assign red_sh = {rem_q, mx_q[W-1]};

  always_comb begin
    st_d = st_q;
    case (st_q)
      mrwt_pkg::ST_IDLE:  if (job_valid_i) begin
        st_d = (job_i.cls == mrwt_pkg::CLS_TEST) ? mrwt_pkg::ST_RED : mrwt_pkg::ST_DONE;
      end
      mrwt_pkg::ST_RED:   if (rcnt_q == '0) st_d = mrwt_pkg::ST_SPLIT;
      mrwt_pkg::ST_SPLIT: if (d_q[0]) st_d = mrwt_pkg::ST_MSEL;
      mrwt_pkg::ST_MSEL:  if (fail_q) st_d = mrwt_pkg::ST_DONE;
        else if (sq_phase_q && s_q == '0) st_d = mrwt_pkg::ST_DONE;
        else if (!sq_phase_q && d_q == '0) st_d = mrwt_pkg::ST_MSEL;
        else st_d = mrwt_pkg::ST_MUL;
      mrwt_pkg::ST_MUL:   if (my_q == '0) st_d = mrwt_pkg::ST_MDONE;
      mrwt_pkg::ST_MDONE: st_d = mrwt_pkg::ST_MSEL;
      mrwt_pkg::ST_DONE:  st_d = mrwt_pkg::ST_IDLE;
      default:            st_d = mrwt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_take_o       = (st_q == mrwt_pkg::ST_IDLE) && job_valid_i;
    done_o           = (st_q == mrwt_pkg::ST_DONE);
    probable_prime_o = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= mrwt_pkg::ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      mrwt_pkg::ST_IDLE: if (job_valid_i) begin
        n_q        <= job_i.n;
        rem_q      <= '0;
        mx_q       <= job_i.a;
        rcnt_q     <= mrwt_pkg::CntBits'(W);
        d_q        <= job_i.n - W'(1);
        s_q        <= '0;
        sq_phase_q <= 1'b0;
        fail_q     <= 1'b0;
        res_q      <= (job_i.cls == mrwt_pkg::CLS_PASS);
        acc_q      <= W'(1);
      end
      mrwt_pkg::ST_RED: begin
        // One restoring step of a mod n, shifting the dividend in from the top.
        base_q <= rem_q;
        rcnt_q <= rcnt_q - mrwt_pkg::CntBits'(1);
        if (rcnt_q != '0) begin
          rem_q <= (red_sh >= {1'b0, n_q}) ? W'(red_sh - {1'b0, n_q}) : red_sh[W-1:0];
          mx_q  <= mx_q << 1;
        end
      end
      mrwt_pkg::ST_SPLIT: if (!d_q[0]) begin
        d_q <= d_q >> 1;
        s_q <= s_q + mrwt_pkg::CntBits'(1);
      end
      mrwt_pkg::ST_MSEL: begin
        mp_q <= '0;
        if (sq_phase_q) begin
          mx_q <= cur_q;
          my_q <= cur_q;
          s_q  <= s_q - mrwt_pkg::CntBits'(1);
          if (s_q == '0 && !fail_q) res_q <= (cur_q == W'(1));
        end else if (d_q == '0) begin
          sq_phase_q <= 1'b1;
          cur_q      <= acc_q;
          prev_q     <= acc_q;
        end else if (d_q[0]) begin
          mx_q <= acc_q; my_q <= base_q; mul_base_q <= 1'b0;
        end else begin
          mx_q <= base_q; my_q <= base_q; mul_base_q <= 1'b1;
        end
        if (fail_q) res_q <= 1'b0;
      end
      mrwt_pkg::ST_MUL: if (my_q != '0) begin
        if (my_q[0]) mp_q <= sum_r;
        mx_q <= dbl_r;
        my_q <= my_q >> 1;
      end
      mrwt_pkg::ST_MDONE: begin
        if (sq_phase_q) begin
          cur_q  <= mp_q;
          prev_q <= mp_q;
          if (mp_q == W'(1) && prev_q != W'(1) && prev_q != nm1) fail_q <= 1'b1;
        end else if (mul_base_q) begin
          base_q <= mp_q;
          d_q    <= d_q >> 1;
        end else begin
          acc_q <= mp_q;
          d_q   <= {d_q[W-1:1], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/miller_rabin_witness_test_core.sv -----
// Top level of the Miller-Rabin witness test core.
// A transaction is accepted when start is high and busy is low; a one-entry queue holds it
// until the back end is free, so one more transaction can be accepted while a test runs.
// A full test reduces the witness, splits off the power of two, and then runs
// at most 122 modular multiplications on the shared shift-and-add multiplier; trivial candidates
// go straight to the result without any multiplication.
// done_o pulses one cycle with probable_prime_o, and the receiver cannot stall it.
module miller_rabin_witness_test_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  mrwt_pkg::value_t candidate_i,
  input  mrwt_pkg::value_t witness_i,
  output logic             done_o,
  output logic             probable_prime_o
);

  logic           job_valid, job_take;
  mrwt_pkg::job_t job;

  mrwt_front u_front (
    .clk_i, .rst_ni, .start_i(start), .candidate_i, .witness_i,
    .busy_o(busy), .job_valid_o(job_valid), .job_o(job), .job_take_i(job_take)
  );

  mrwt_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .job_take_o(job_take),
    .done_o, .probable_prime_o
  );

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("done held for more than one cycle");
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction not held");
  a_done_known: assert property (@(posedge clk_i) disable iff (!rst_ni) !$isunknown(done_o))
    else $error("done is unknown");

endmodule

// ----- sim/mrwt_checker.sv -----
// Checker that predicts and compares Miller-Rabin witness test results.
module mrwt_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             busy,
  input  mrwt_pkg::value_t candidate_i,
  input  mrwt_pkg::value_t witness_i,
  input  logic             done_o,
  input  logic             probable_prime_o,
  output int               fail_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  bit verdict_q[$];

  function automatic bit [63:0] mulmod(bit [63:0] x, bit [63:0] y, bit [63:0] m);
    bit [63:0] acc;
    acc = 0;
    x = x % m;
    y = y % m;
    while (y != 0) begin
      if (y[0]) begin
        acc = acc + x;
        if (acc >= m) acc = acc - m;
      end
      x = x << 1;
      if (x >= m) x = x - m;
      y = y >> 1;
    end
    return acc;
  endfunction

  function automatic bit strong_prime(bit [63:0] n, bit [63:0] a);
    bit [63:0] d, cur, prev, base, e;
    int s;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    d = n - 1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    cur = 1 % n;
    base = a % n;
    e = d;
    while (e != 0) begin
      if (e[0]) cur = mulmod(cur, base, n);
      base = mulmod(base, base, n);
      e = e >> 1;
    end
    prev = cur;
    for (int i = 0; i < s; i++) begin
      cur = mulmod(cur, cur, n);
      if (cur == 1 && prev != 1 && prev != n - 1) return 1'b0;
      prev = cur;
    end
    return cur == 1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        verdict_q.insert(verdict_q.size(),
                         strong_prime({2'b0, candidate_i}, {2'b0, witness_i}));
      end
      if (done_o) begin
        if (verdict_q.size() == 0) begin
          $error("probable_prime: unexpected result %0b", probable_prime_o);
          fail_count++;
        end else begin
          if (probable_prime_o !== verdict_q[0]) begin
            $error("probable_prime: expected %0b, actual %0b", verdict_q[0], probable_prime_o);
            fail_count++;
          end
          void'(verdict_q.pop_front());
        end
      end
    end
    pending_count = verdict_q.size();
  end
endmodule

// ----- sim/tb.sv -----
// Testbench top: drives candidate and witness pairs into the witness test core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             start = 0;
  logic             busy, done_o, probable_prime_o;
  mrwt_pkg::value_t candidate_i = '0;
  mrwt_pkg::value_t witness_i = '0;
  int               fail_count, pending_count;

  always #4 clk_i = ~clk_i;

  miller_rabin_witness_test_core DUT (.*);
  mrwt_checker u_checker (.*);

  function automatic mrwt_pkg::value_t rand_value();
    return mrwt_pkg::value_t'({$urandom(), $urandom()});
  endfunction

  task automatic send(mrwt_pkg::value_t n, mrwt_pkg::value_t a, bit allow_gap);
    if (allow_gap) begin
      while ($urandom_range(99) < 26) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    end
    candidate_i <= n;
    witness_i <= a;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  initial begin
    mrwt_pkg::value_t n;
    mrwt_pkg::value_t directed_n[14] = '{62'd0, 62'd1, 62'd2, 62'd3, 62'd4, 62'd97, 62'd561,
                              62'd2047, 62'd341, 62'h3FFFFFFFFFFFFFFF,
                              62'h3FFFFFFFFFFFFFC5, 62'd1000003, 62'd25,
                              62'h3FFFFFFFFFFFFFFE};
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    foreach (directed_n[i]) send(directed_n[i], 62'd2, 1'b0);
    send(62'd97, 62'd97, 1'b0);
    send(62'd97, 62'd0, 1'b0);
    send(62'd97, 62'd195, 1'b0);
    send(62'd2, 62'h3FFFFFFFFFFFFFFF, 1'b0);
    send(62'd0, 62'd0, 1'b0);
    send(62'd341, 62'd340, 1'b0);
    send(62'h3FFFFFFFFFFFFFC5, 62'h3FFFFFFFFFFFFFC4, 1'b0);
    send(62'h3FFFFFFFFFFFFFFF, 62'h2AAAAAAAAAAAAAAA, 1'b0);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    for (int i = 0; i < 80; i++) begin
      case ($urandom_range(3))
        0: n = rand_value();
        1: n = rand_value() | 62'd1;
        2: n = mrwt_pkg::value_t'($urandom_range(5000)) | 62'd1;
        default: n = {16'($urandom_range(65535)), 46'b0} | 62'd1;
      endcase
      send(n, ($urandom_range(3) == 0) ? rand_value() : (rand_value() % (n > 62'd1 ? n : 62'd1)),
           i >= 30);
    end
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("tb failed");
    $finish;
  end
endmodule

// ----- files.f -----
sv/mrwt_pkg.sv
sv/mrwt_front.sv
sv/mrwt_back.sv
sv/miller_rabin_witness_test_core.sv
sim/mrwt_checker.sv
sim/tb.sv
